// File: rtl/core/srm_pkg.sv
// Shared constants, CORDIC tables and queue item type for the spherical rotation matrix block.
package srm_pkg;

   localparam int ANGLE_BITS_DEFAULT    = 16;
   localparam int FRACTION_BITS_DEFAULT = 14;

   // angles are scaled to a 32-bit turn; top two bits are the quadrant
   localparam int TURN_BITS      = 32;
   localparam int CORDIC_FRAC    = 30;
   localparam int CORDIC_STEPS   = 31;
   localparam int CORDIC_XY_BITS = 33;
   localparam int CORDIC_Z_BITS  = 32;

   localparam logic signed [CORDIC_XY_BITS-1:0] CORDIC_GAIN = 33'sd652032874;

   // atan(2^-i) in units of 2pi / 2^32
   localparam logic signed [CORDIC_Z_BITS-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
      32'sd21354465,  32'sd10679838,  32'sd5340245,   32'sd2670163,  32'sd1335087,
      32'sd667544,    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41722,
      32'sd20861,     32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,       32'sd41,
      32'sd20,        32'sd10,        32'sd5,         32'sd3,        32'sd1,
      32'sd1
   };

   localparam int TAG_BITS  = 8;
   localparam int DIST_BITS = 24;
   localparam int POS_BITS  = 25;

   localparam logic [DIST_BITS-1:0]       DIST_RESET = 24'd256;
   localparam logic signed [POS_BITS-1:0] POS_MAX    = 25'sd16777215;

   // power of two, so the queue pointers wrap on their own
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   typedef struct packed {
      logic [1:0]             theta_quad;
      logic [CORDIC_FRAC-1:0] theta_resid;
      logic [1:0]             phi_quad;
      logic [CORDIC_FRAC-1:0] phi_resid;
      logic [TAG_BITS-1:0]    tag;
   } srm_item_type;

endpackage

// File: rtl/core/spherical_rotation_matrix_top.sv
// Top level of the spherical-angle rotation matrix and observer position block.
//
// Request channel (req_*): theta and phi as binary angles (full word = one turn) plus an
// observer tag. A request is taken on a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): the tag, eight rotation-matrix entries (entry [1][2] is always
// zero and is not sent) and the observer position distance * (st*cp, st*sp, ct), rounded
// and saturated. A response is taken on an edge with rsp_valid high and rsp_stall low.
// Config: csr_wr_en/csr_wr_data load the observer distance (8 fraction bits); write it
// only while no request is in flight.
// Throughput: one request per cycle while no receiver stall freezes the pipeline. A request
// passes through the front register, a queue slot, the 31-stage CORDIC pipeline, quadrant
// fix-up, matrix product, rounding, position product and output register.
// A receiver stall while a response is waiting freezes the whole compute pipeline; the
// 4-entry queue and the front register then absorb five more requests before req_stall rises.
// Reset (synchronous) empties the front register, queue and pipeline and sets the
// distance to 1.0.
module spherical_rotation_matrix_top #(
   parameter int ANGLE_BITS    = srm_pkg::ANGLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = srm_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [srm_pkg::DIST_BITS-1:0]        csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ANGLE_BITS-1:0]                req_theta_angle,
   input  logic [ANGLE_BITS-1:0]                req_phi_angle,
   input  logic [srm_pkg::TAG_BITS-1:0]         req_observer_tag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [srm_pkg::TAG_BITS-1:0]         rsp_tag_out,
   output logic signed [FRACTION_BITS+1:0]      rsp_m00,
   output logic signed [FRACTION_BITS+1:0]      rsp_m01,
   output logic signed [FRACTION_BITS+1:0]      rsp_m02,
   output logic signed [FRACTION_BITS+1:0]      rsp_m10,
   output logic signed [FRACTION_BITS+1:0]      rsp_m11,
   output logic signed [FRACTION_BITS+1:0]      rsp_m20,
   output logic signed [FRACTION_BITS+1:0]      rsp_m21,
   output logic signed [FRACTION_BITS+1:0]      rsp_m22,
   output logic signed [srm_pkg::POS_BITS-1:0]  rsp_pos_x,
   output logic signed [srm_pkg::POS_BITS-1:0]  rsp_pos_y,
   output logic signed [srm_pkg::POS_BITS-1:0]  rsp_pos_z
);
   import srm_pkg::*;

   localparam int MB = FRACTION_BITS + 2;
   localparam logic signed [MB-1:0] MAT_ONE = MB'(1) << FRACTION_BITS;

   // distance register, read straight by the position stage
   logic [DIST_BITS-1:0] distance_ff, distance_in;

   logic         q_full;
   logic         push_valid;
   srm_item_type push_item;
   logic         pop_valid;
   logic         pop_ready;
   srm_item_type pop_item;

   assign distance_in = csr_wr_en ? csr_wr_data : distance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         distance_ff <= DIST_RESET;
      end else begin
         distance_ff <= distance_in;
      end
   end

   // front: takes requests, splits quadrant from residual angle
   srm_front #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_theta_angle  (req_theta_angle),
      .req_phi_angle    (req_phi_angle),
      .req_observer_tag (req_observer_tag),
      .q_full           (q_full),
      .push_valid       (push_valid),
      .push_item        (push_item)
   );

   // queue between front and back so each side stalls on its own
   srm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   // back: CORDIC lanes, matrix, position and response register
   srm_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_item    (pop_item),
      .pop_ready   (pop_ready),
      .distance    (distance_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_tag_out (rsp_tag_out),
      .rsp_m00     (rsp_m00),
      .rsp_m01     (rsp_m01),
      .rsp_m02     (rsp_m02),
      .rsp_m10     (rsp_m10),
      .rsp_m11     (rsp_m11),
      .rsp_m20     (rsp_m20),
      .rsp_m21     (rsp_m21),
      .rsp_m22     (rsp_m22),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_pos_z   (rsp_pos_z)
   );

   // front only holds off requests when the queue is full
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_full)
      else $error("request stalled while queue has room");

   // no response right after reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // cos theta stays inside the unit range after clamping and quadrant fix-up
   a_m22_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m22 <= MAT_ONE) && (rsp_m22 >= -MAT_ONE))
      else $error("m22 out of unit range");

   // distance is unsigned, so pos_z cannot be negative when cos theta is not
   a_pos_z_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_m22[MB-1] |-> !rsp_pos_z[POS_BITS-1])
      else $error("pos_z sign disagrees with m22");

endmodule

// File: rtl/core/srm_front.sv
// Front end: takes requests, splits each angle into quadrant and residual, feeds the queue.
module srm_front #(
   parameter int ANGLE_BITS = srm_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ANGLE_BITS-1:0]        req_theta_angle,
   input  logic [ANGLE_BITS-1:0]        req_phi_angle,
   input  logic [srm_pkg::TAG_BITS-1:0] req_observer_tag,
   input  logic                         q_full,
   output logic                         push_valid,
   output srm_pkg::srm_item_type        push_item
);
   import srm_pkg::*;

   localparam int SCALE_SHIFT = TURN_BITS - ANGLE_BITS;

   logic                 valid_ff, valid_in;
   srm_item_type         item_ff, item_in;
   logic [TURN_BITS-1:0] theta_turn, phi_turn;
   logic                 load;

   assign theta_turn = TURN_BITS'(req_theta_angle) << SCALE_SHIFT;
   assign phi_turn   = TURN_BITS'(req_phi_angle) << SCALE_SHIFT;

   assign req_stall = valid_ff && q_full;
   assign load      = req_valid && !req_stall;
   assign valid_in  = req_stall || req_valid;

   always_comb begin
      item_in.theta_quad  = theta_turn[TURN_BITS-1 -: 2];
      item_in.theta_resid = theta_turn[CORDIC_FRAC-1:0];
      item_in.phi_quad    = phi_turn[TURN_BITS-1 -: 2];
      item_in.phi_resid   = phi_turn[CORDIC_FRAC-1:0];
      item_in.tag         = req_observer_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

// File: rtl/core/srm_queue.sv
// Small FIFO that decouples the front end from the compute pipeline.
module srm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  srm_pkg::srm_item_type push_item,
   output logic                  full,
   input  logic                  pop_ready,
   output logic                  pop_valid,
   output srm_pkg::srm_item_type pop_item
);
   import srm_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   srm_item_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                push, pop;

   assign full      = count_ff == (PTR_BITS + 1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/srm_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration, giving cos and sin over [0, pi/2).
module srm_cordic (
   input  logic                                        clock,
   input  logic                                        enable,
   input  logic [srm_pkg::CORDIC_FRAC-1:0]             in_resid,
   output logic signed [srm_pkg::CORDIC_XY_BITS-1:0]   out_x,
   output logic signed [srm_pkg::CORDIC_XY_BITS-1:0]   out_y
);
   import srm_pkg::*;

   localparam int XY = CORDIC_XY_BITS;
   localparam int ZB = CORDIC_Z_BITS;

   logic signed [XY-1:0] x_ff [CORDIC_STEPS];
   logic signed [XY-1:0] y_ff [CORDIC_STEPS];
   logic signed [ZB-1:0] z_ff [CORDIC_STEPS];
   logic signed [XY-1:0] x_in [CORDIC_STEPS];
   logic signed [XY-1:0] y_in [CORDIC_STEPS];
   logic signed [ZB-1:0] z_in [CORDIC_STEPS];
   logic signed [XY-1:0] x_src [CORDIC_STEPS];
   logic signed [XY-1:0] y_src [CORDIC_STEPS];
   logic signed [ZB-1:0] z_src [CORDIC_STEPS];

   assign x_src[0] = CORDIC_GAIN;
   assign y_src[0] = '0;
   assign z_src[0] = $signed({{(ZB - CORDIC_FRAC){1'b0}}, in_resid});

   for (genvar i = 1; i < CORDIC_STEPS; i++) begin : g_link
      assign x_src[i] = x_ff[i-1];
      assign y_src[i] = y_ff[i-1];
      assign z_src[i] = z_ff[i-1];
   end

   // rotate toward zero residual; shifts floor like the arithmetic shift
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      assign x_in[i] = z_src[i][ZB-1] ? x_src[i] + (y_src[i] >>> i)
                                      : x_src[i] - (y_src[i] >>> i);
      assign y_in[i] = z_src[i][ZB-1] ? y_src[i] - (x_src[i] >>> i)
                                      : y_src[i] + (x_src[i] >>> i);
      assign z_in[i] = z_src[i][ZB-1] ? z_src[i] + ATAN_TABLE[i]
                                      : z_src[i] - ATAN_TABLE[i];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
         end
      end
   end

   assign out_x = x_ff[CORDIC_STEPS-1];
   assign out_y = y_ff[CORDIC_STEPS-1];

endmodule

// File: rtl/core/srm_back.sv
// Back end: CORDIC lanes, quadrant fix-up, matrix products, position and output register.
module srm_back #(
   parameter int FRACTION_BITS = srm_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   input  srm_pkg::srm_item_type                pop_item,
   output logic                                 pop_ready,
   input  logic [srm_pkg::DIST_BITS-1:0]        distance,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [srm_pkg::TAG_BITS-1:0]         rsp_tag_out,
   output logic signed [FRACTION_BITS+1:0]      rsp_m00,
   output logic signed [FRACTION_BITS+1:0]      rsp_m01,
   output logic signed [FRACTION_BITS+1:0]      rsp_m02,
   output logic signed [FRACTION_BITS+1:0]      rsp_m10,
   output logic signed [FRACTION_BITS+1:0]      rsp_m11,
   output logic signed [FRACTION_BITS+1:0]      rsp_m20,
   output logic signed [FRACTION_BITS+1:0]      rsp_m21,
   output logic signed [FRACTION_BITS+1:0]      rsp_m22,
   output logic signed [srm_pkg::POS_BITS-1:0]  rsp_pos_x,
   output logic signed [srm_pkg::POS_BITS-1:0]  rsp_pos_y,
   output logic signed [srm_pkg::POS_BITS-1:0]  rsp_pos_z
);
   import srm_pkg::*;

   localparam int MB    = FRACTION_BITS + 2;
   localparam int XY    = CORDIC_XY_BITS;
   localparam int SHIFT = CORDIC_FRAC - FRACTION_BITS;
   localparam int PB    = 2 * MB;
   localparam int DB    = DIST_BITS + 1;
   localparam int QB    = DB + MB;

   localparam logic signed [XY-1:0] TRIG_HALF = XY'((SHIFT == 0) ? 0 : (1 << (SHIFT - 1)));
   localparam logic signed [XY-1:0] TRIG_ONE  = XY'(1) << FRACTION_BITS;
   localparam logic signed [PB-1:0] PROD_HALF = PB'(1) << (FRACTION_BITS - 1);
   localparam logic signed [QB-1:0] POS_HALF  = QB'(1) << (FRACTION_BITS - 1);
   localparam logic signed [QB-1:0] POS_LIM   = QB'(POS_MAX);

   typedef struct packed {
      logic signed [MB-1:0] st;
      logic signed [MB-1:0] ct;
      logic signed [MB-1:0] sp;
      logic signed [MB-1:0] cp;
   } trig_type;

   typedef struct packed {
      logic signed [MB-1:0] m00;
      logic signed [MB-1:0] m01;
      logic signed [MB-1:0] m02;
      logic signed [MB-1:0] m10;
      logic signed [MB-1:0] m11;
      logic signed [MB-1:0] m20;
      logic signed [MB-1:0] m21;
      logic signed [MB-1:0] m22;
   } mat_type;

   function automatic logic signed [MB-1:0] round_trig(input logic signed [XY-1:0] v);
      logic signed [XY-1:0] r;
      r = (v + TRIG_HALF) >>> SHIFT;
      if (r > TRIG_ONE) begin
         r = TRIG_ONE;
      end else if (r < -TRIG_ONE) begin
         r = -TRIG_ONE;
      end
      return r[MB-1:0];
   endfunction

   function automatic logic signed [MB-1:0] round_prod(input logic signed [PB-1:0] p);
      logic signed [PB-1:0] r;
      r = (p + PROD_HALF) >>> FRACTION_BITS;
      return r[MB-1:0];
   endfunction

   function automatic logic signed [POS_BITS-1:0] round_pos(input logic signed [QB-1:0] q);
      logic signed [QB-1:0] r;
      r = (q + POS_HALF) >>> FRACTION_BITS;
      if (r > POS_LIM) begin
         r = POS_LIM;
      end else if (r < -POS_LIM) begin
         r = -POS_LIM;
      end
      return r[POS_BITS-1:0];
   endfunction

   logic enable;

   // CORDIC side lines
   logic [CORDIC_STEPS-1:0] cv_ff, cv_in;
   logic [1:0]              tq_ff  [CORDIC_STEPS];
   logic [1:0]              pq_ff  [CORDIC_STEPS];
   logic [TAG_BITS-1:0]     ctg_ff [CORDIC_STEPS];
   logic signed [XY-1:0]    theta_x, theta_y, phi_x, phi_y;

   // trig stage
   logic signed [MB-1:0] theta_c, theta_s, phi_c, phi_s;
   trig_type             trig_ff, trig_in;
   logic                 tv_ff;
   logic [TAG_BITS-1:0]  ttg_ff;

   // product stage
   logic signed [PB-1:0] p00_ff, p01_ff, p20_ff, p21_ff;
   logic signed [PB-1:0] p00_in, p01_in, p20_in, p21_in;
   trig_type             trig2_ff;
   logic                 pv_ff;
   logic [TAG_BITS-1:0]  ptg_ff;

   // matrix stage
   mat_type              mat_ff, mat_in;
   logic                 mv_ff;
   logic [TAG_BITS-1:0]  mtg_ff;

   // position product stage
   logic signed [DB-1:0] dist_s;
   logic signed [QB-1:0] qx_ff, qy_ff, qz_ff, qx_in, qy_in, qz_in;
   mat_type              mat2_ff;
   logic                 qv_ff;
   logic [TAG_BITS-1:0]  qtg_ff;

   // output register
   logic                         rsp_valid_ff;
   mat_type                      out_mat_ff;
   logic [TAG_BITS-1:0]          out_tag_ff;
   logic signed [POS_BITS-1:0]   pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [POS_BITS-1:0]   pos_x_in, pos_y_in, pos_z_in;

   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign pop_ready = enable;

   srm_cordic u_theta (
      .clock    (clock),
      .enable   (enable),
      .in_resid (pop_item.theta_resid),
      .out_x    (theta_x),
      .out_y    (theta_y)
   );

   srm_cordic u_phi (
      .clock    (clock),
      .enable   (enable),
      .in_resid (pop_item.phi_resid),
      .out_x    (phi_x),
      .out_y    (phi_y)
   );

   assign cv_in = {cv_ff[CORDIC_STEPS-2:0], pop_valid};

   always_ff @(posedge clock) begin
      if (enable) begin
         tq_ff[0]  <= pop_item.theta_quad;
         pq_ff[0]  <= pop_item.phi_quad;
         ctg_ff[0] <= pop_item.tag;
         for (int k = 1; k < CORDIC_STEPS; k++) begin
            tq_ff[k]  <= tq_ff[k-1];
            pq_ff[k]  <= pq_ff[k-1];
            ctg_ff[k] <= ctg_ff[k-1];
         end
      end
   end

   // round, clamp and fold the quadrant back in by swaps and negations
   always_comb begin
      theta_c = round_trig(theta_x);
      theta_s = round_trig(theta_y);
      phi_c   = round_trig(phi_x);
      phi_s   = round_trig(phi_y);
      case (tq_ff[CORDIC_STEPS-1])
         QUAD_FIRST: begin
            trig_in.ct = theta_c;
            trig_in.st = theta_s;
         end
         QUAD_SECOND: begin
            trig_in.ct = -theta_s;
            trig_in.st = theta_c;
         end
         QUAD_THIRD: begin
            trig_in.ct = -theta_c;
            trig_in.st = -theta_s;
         end
         QUAD_FOURTH: begin
            trig_in.ct = theta_s;
            trig_in.st = -theta_c;
         end
         default: begin
            trig_in.ct = theta_c;
            trig_in.st = theta_s;
         end
      endcase
      case (pq_ff[CORDIC_STEPS-1])
         QUAD_FIRST: begin
            trig_in.cp = phi_c;
            trig_in.sp = phi_s;
         end
         QUAD_SECOND: begin
            trig_in.cp = -phi_s;
            trig_in.sp = phi_c;
         end
         QUAD_THIRD: begin
            trig_in.cp = -phi_c;
            trig_in.sp = -phi_s;
         end
         QUAD_FOURTH: begin
            trig_in.cp = phi_s;
            trig_in.sp = -phi_c;
         end
         default: begin
            trig_in.cp = phi_c;
            trig_in.sp = phi_s;
         end
      endcase
   end

   always_comb begin
      p00_in = trig_ff.ct * trig_ff.cp;
      p01_in = trig_ff.ct * trig_ff.sp;
      p20_in = trig_ff.st * trig_ff.cp;
      p21_in = trig_ff.st * trig_ff.sp;
   end

   always_comb begin
      mat_in.m00 = round_prod(p00_ff);
      mat_in.m01 = round_prod(p01_ff);
      mat_in.m02 = -trig2_ff.st;
      mat_in.m10 = -trig2_ff.sp;
      mat_in.m11 = trig2_ff.cp;
      mat_in.m20 = round_prod(p20_ff);
      mat_in.m21 = round_prod(p21_ff);
      mat_in.m22 = trig2_ff.ct;
   end

   assign dist_s = $signed({1'b0, distance});

   always_comb begin
      qx_in = dist_s * mat_ff.m20;
      qy_in = dist_s * mat_ff.m21;
      qz_in = dist_s * mat_ff.m22;
   end

   always_comb begin
      pos_x_in = round_pos(qx_ff);
      pos_y_in = round_pos(qy_ff);
      pos_z_in = round_pos(qz_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff        <= '0;
         tv_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         mv_ff        <= 1'b0;
         qv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         cv_ff        <= cv_in;
         tv_ff        <= cv_ff[CORDIC_STEPS-1];
         pv_ff        <= tv_ff;
         mv_ff        <= pv_ff;
         qv_ff        <= mv_ff;
         rsp_valid_ff <= qv_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (enable) begin
         trig_ff    <= trig_in;
         ttg_ff     <= ctg_ff[CORDIC_STEPS-1];
         p00_ff     <= p00_in;
         p01_ff     <= p01_in;
         p20_ff     <= p20_in;
         p21_ff     <= p21_in;
         trig2_ff   <= trig_ff;
         ptg_ff     <= ttg_ff;
         mat_ff     <= mat_in;
         mtg_ff     <= ptg_ff;
         qx_ff      <= qx_in;
         qy_ff      <= qy_in;
         qz_ff      <= qz_in;
         mat2_ff    <= mat_ff;
         qtg_ff     <= mtg_ff;
         out_mat_ff <= mat2_ff;
         out_tag_ff <= qtg_ff;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         pos_z_ff   <= pos_z_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tag_out = out_tag_ff;
   assign rsp_m00     = out_mat_ff.m00;
   assign rsp_m01     = out_mat_ff.m01;
   assign rsp_m02     = out_mat_ff.m02;
   assign rsp_m10     = out_mat_ff.m10;
   assign rsp_m11     = out_mat_ff.m11;
   assign rsp_m20     = out_mat_ff.m20;
   assign rsp_m21     = out_mat_ff.m21;
   assign rsp_m22     = out_mat_ff.m22;
   assign rsp_pos_x   = pos_x_ff;
   assign rsp_pos_y   = pos_y_ff;
   assign rsp_pos_z   = pos_z_ff;

endmodule
